// ===== hw/rtl/ptw_pkg.sv =====
// ============================================================================
// ptw_pkg - shared types for the page table walker
// Transaction payloads, controller states, and the command/status bundles
// that join the controller to the datapath.
// ============================================================================
package ptw_pkg;

    localparam int DEF_OFFSET_BITS    = 4;
    localparam int DEF_TABLE_LEVELS   = 4;
    localparam int DEF_PHYS_ADDR_BITS = 10;
    localparam int DEF_VIRT_ADDR_BITS = 20;
    localparam int DEF_WORD_BITS      = 32;

    typedef struct packed {
        logic               command;
        logic [23:0]        virtual_address;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               success;
    } rsp_t;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_W_RD,
        ST_W_CHK,
        ST_SC_ENTER,
        ST_Z_RD,
        ST_Z_CHK,
        ST_IT_RD,
        ST_IT_CHK,
        ST_RET,
        ST_LEAF_A,
        ST_LEAF_B,
        ST_DECIDE,
        ST_CP_RD,
        ST_CP_WR,
        ST_UNLINK,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_LINK,
        ST_D_ACC,
        ST_D_RES,
        ST_DONE
    } ctl_state_t;

    // physical memory address source
    typedef enum logic [3:0] {
        PA_NONE,
        PA_ENTRY,
        PA_ZERO,
        PA_ITER,
        PA_PARENT,
        PA_NF,
        PA_LINK,
        PA_DATA,
        PA_CLEAR
    } phys_sel_t;

    // swap memory address source
    typedef enum logic [1:0] {
        SA_NONE,
        SA_OUT,
        SA_IN,
        SA_CLEAR
    } swap_sel_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_WRITE,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      walk_init;
        logic      walk_adv;
        logic      adv_from_nf;
        logic      fault_init;
        logic      sc_enter;
        logic      push;
        logic      wc_inc;
        logic      mark_empty;
        logic      descend;
        logic      iter_miss;
        logic      pop;
        logic      leaf_a;
        logic      leaf_b;
        logic      decide;
        logic      clr_step;
        logic      set_res;
        res_sel_t  res_sel;
        logic      out_load;
        phys_sel_t phys_sel;
        logic      phys_we;
        swap_sel_t swap_sel;
        logic      swap_we;
    } ptw_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic va_ok;
        logic is_write;
        logic next_nz;
        logic walk_last;
        logic at_leaf;
        logic not_forbid;
        logic rd_nz;
        logic wc_last;
        logic si_cur_last;
        logic si_up_last;
        logic sl_zero;
        logic empty_nz;
        logic room;
        logic out_free;
    } ptw_status_t;

endpackage

// ===== hw/rtl/ptw_ctrl.sv =====
// ============================================================================
// ptw_ctrl - walk / fault / scan sequencer
// Steps the datapath through the walk, the depth-first scan on a fault,
// frame replacement and the final data access.
// ============================================================================
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  ptw_status_t st,
    output ptw_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                cmd.phys_sel = PA_CLEAR;
                cmd.phys_we  = 1'b1;
                cmd.swap_sel = SA_CLEAR;
                cmd.swap_we  = 1'b1;
                if (st.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.va_ok)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_W_RD;
                end
                else
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_FAIL;
                    state_next  = ST_DONE;
                end
            end
            ST_W_RD:
            begin
                cmd.phys_sel = PA_ENTRY;
                state_next   = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (st.next_nz)
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = st.walk_last ? ST_D_ACC : ST_W_RD;
                end
                else
                begin
                    cmd.fault_init = 1'b1;
                    state_next     = ST_SC_ENTER;
                end
            end
            ST_SC_ENTER:
            begin
                cmd.sc_enter = 1'b1;
                priority if (st.at_leaf)
                begin
                    state_next = ST_LEAF_A;
                end
                else if (st.not_forbid)
                begin
                    state_next = ST_Z_RD;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IT_RD;
                end
            end
            ST_Z_RD:
            begin
                cmd.phys_sel = PA_ZERO;
                state_next   = ST_Z_CHK;
            end
            ST_Z_CHK:
            begin
                priority if (st.rd_nz)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IT_RD;
                end
                else if (st.wc_last)
                begin
                    cmd.mark_empty = 1'b1;
                    state_next     = ST_RET;
                end
                else
                begin
                    cmd.wc_inc = 1'b1;
                    state_next = ST_Z_RD;
                end
            end
            ST_IT_RD:
            begin
                cmd.phys_sel = PA_ITER;
                state_next   = ST_IT_CHK;
            end
            ST_IT_CHK:
            begin
                if (st.rd_nz)
                begin
                    cmd.descend = 1'b1;
                    state_next  = ST_SC_ENTER;
                end
                else
                begin
                    cmd.iter_miss = 1'b1;
                    state_next    = st.si_cur_last ? ST_RET : ST_IT_RD;
                end
            end
            ST_RET:
            begin
                if (st.sl_zero)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = st.si_up_last ? ST_RET : ST_IT_RD;
                end
            end
            ST_LEAF_A:
            begin
                cmd.leaf_a = 1'b1;
                state_next = ST_LEAF_B;
            end
            ST_LEAF_B:
            begin
                cmd.leaf_b = 1'b1;
                state_next = ST_RET;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (st.empty_nz)
                begin
                    state_next = ST_UNLINK;
                end
                else if (st.room)
                begin
                    state_next = ST_FILL_RD;
                end
                else
                begin
                    state_next = ST_CP_RD;
                end
            end
            ST_CP_RD:
            begin
                cmd.phys_sel = PA_NF;
                state_next   = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                cmd.swap_sel = SA_OUT;
                cmd.swap_we  = 1'b1;
                cmd.wc_inc   = 1'b1;
                state_next   = st.wc_last ? ST_UNLINK : ST_CP_RD;
            end
            ST_UNLINK:
            begin
                cmd.phys_sel = PA_PARENT;
                cmd.phys_we  = 1'b1;
                state_next   = ST_FILL_RD;
            end
            ST_FILL_RD:
            begin
                cmd.swap_sel = SA_IN;
                state_next   = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.phys_sel = PA_NF;
                cmd.phys_we  = 1'b1;
                cmd.wc_inc   = 1'b1;
                state_next   = st.wc_last ? ST_LINK : ST_FILL_RD;
            end
            ST_LINK:
            begin
                cmd.phys_sel    = PA_LINK;
                cmd.phys_we     = 1'b1;
                cmd.walk_adv    = 1'b1;
                cmd.adv_from_nf = 1'b1;
                state_next      = st.walk_last ? ST_D_ACC : ST_W_RD;
            end
            ST_D_ACC:
            begin
                cmd.phys_sel = PA_DATA;
                if (st.is_write)
                begin
                    cmd.phys_we = 1'b1;
                    cmd.set_res = 1'b1;
                    cmd.res_sel = RES_WRITE;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_D_RES;
                end
            end
            ST_D_RES:
            begin
                cmd.set_res = 1'b1;
                cmd.res_sel = RES_READ;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ptw_datapath.sv =====
// ============================================================================
// ptw_datapath - memories, walk registers, scan stack and output register
// Physical word memory and swap memory (single port each), the scan stack
// per table level, scan bookkeeping and the response register.
// ============================================================================
module ptw_datapath
    import ptw_pkg::*;
#(
    parameter int OFFSET_BITS    = DEF_OFFSET_BITS,
    parameter int TABLE_LEVELS   = DEF_TABLE_LEVELS,
    parameter int PHYS_ADDR_BITS = DEF_PHYS_ADDR_BITS,
    parameter int VIRT_ADDR_BITS = DEF_VIRT_ADDR_BITS,
    parameter int WORD_BITS      = DEF_WORD_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  ptw_cmd_t    cmd,
    output ptw_status_t st
);

    localparam int OFF        = OFFSET_BITS;
    localparam int TL         = TABLE_LEVELS;
    localparam int WB         = WORD_BITS;
    localparam int FRAME_BITS = (PHYS_ADDR_BITS > OFF) ? (PHYS_ADDR_BITS - OFF) : 0;
    localparam int FR_W       = (FRAME_BITS > 0) ? FRAME_BITS : 1;
    localparam int PA_W       = FRAME_BITS + OFF;
    localparam int PN         = (VIRT_ADDR_BITS > OFF) ? (VIRT_ADDR_BITS - OFF) : 0;
    localparam int PN_W       = (PN > 0) ? PN : 1;
    localparam int SW_AW      = PN + OFF;
    localparam int IDX_W      = OFF * TL;
    localparam int CNT_W      = ((PN > IDX_W) ? PN : IDX_W) + 1;
    localparam int LVL_W      = (TL > 1) ? $clog2(TL) : 1;
    localparam int SL_W       = $clog2(TL + 1);
    localparam int CLR_W      = (PA_W > SW_AW) ? PA_W : SW_AW;
    localparam int PHYS_DEPTH = 1 << PA_W;
    localparam int SWAP_DEPTH = 1 << SW_AW;

    localparam logic [FR_W-1:0]  FR_MASK = (FRAME_BITS == 0) ? '0 : '1;
    localparam logic [CNT_W-1:0] NP_C    = CNT_W'(1) << PN;

    function automatic logic [PA_W-1:0] paddr(input logic [FR_W-1:0] f,
                                              input logic [OFF-1:0] i);
        logic [FR_W+OFF-1:0] t;
        begin
            t = {f, i};
            return t[PA_W-1:0];
        end
    endfunction

    function automatic logic [SW_AW-1:0] saddr(input logic [PN_W-1:0] p,
                                               input logic [OFF-1:0] i);
        logic [PN_W+OFF-1:0] t;
        begin
            t = {p, i};
            return t[SW_AW-1:0];
        end
    endfunction

    function automatic logic [FR_W-1:0] to_frame(input logic [WB-1:0] w);
        logic [WB+FR_W-1:0] t;
        begin
            t = {FR_W'(0), w};
            return t[FR_W-1:0] & FR_MASK;
        end
    endfunction

    // memories
    logic [WB-1:0] phys_mem [PHYS_DEPTH];
    logic [WB-1:0] swap_mem [SWAP_DEPTH];
    logic [WB-1:0] phys_rd_reg;
    logic [WB-1:0] swap_rd_reg;
    logic [PA_W-1:0]  pa;
    logic [WB-1:0]    pwd;
    logic [SW_AW-1:0] sa;
    logic [WB-1:0]    swd;

    // transaction and walk
    req_t             req_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [FR_W-1:0]  frame_reg;
    logic [FR_W-1:0]  forbid_reg;
    logic [PA_W-1:0]  entry_reg;
    logic [FR_W-1:0]  nf_reg;
    logic [OFF-1:0]   wc_reg;

    // scan
    logic [SL_W-1:0]  sl_reg;
    logic [FR_W-1:0]  cur_frame_reg;
    logic [PA_W-1:0]  cur_parent_reg;
    logic [FR_W-1:0]  sf_reg [TL];
    logic [OFF-1:0]   si_reg [TL];
    logic [FR_W-1:0]  max_frame_reg;
    logic [CNT_W-1:0] pc_reg;
    logic [CNT_W-1:0] diff_reg;
    logic [CNT_W-1:0] best_dist_reg;
    logic [FR_W-1:0]  best_frame_reg;
    logic [PA_W-1:0]  best_parent_reg;
    logic [PN_W-1:0]  best_page_reg;
    logic [FR_W-1:0]  empty_frame_reg;
    logic [PA_W-1:0]  empty_parent_reg;

    // result and control
    logic [31:0]      res_value_reg;
    logic             res_ok_reg;
    rsp_t             out_reg;
    logic             out_valid_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    // derived values
    logic [PN_W-1:0]       page;
    logic [OFF-1:0]        offset;
    logic [LVL_W-1:0]      lvl_rem;
    logic [IDX_W+PN_W-1:0] page_ext;
    logic [IDX_W+PN_W-1:0] page_sh;
    logic [OFF-1:0]        lvl_idx;
    logic [PA_W-1:0]       entry_addr;
    logic [LVL_W-1:0]      slx;
    logic [SL_W-1:0]       sl_dec;
    logic [LVL_W-1:0]      slu;
    logic [PA_W-1:0]       iter_addr;
    logic [SL_W-1:0]       sl_rem;
    logic [CNT_W-1:0]      span;
    logic [CNT_W-1:0]      target;
    logic [CNT_W-1:0]      alt;
    logic [CNT_W-1:0]      cyc_dist;
    logic [FR_W-1:0]       rd_frame;
    logic [WB+FR_W-1:0]    nf_wide;
    logic signed [WB-1:0]  rd_signed;

    assign page     = PN_W'(req_reg.virtual_address >> OFF);
    assign offset   = req_reg.virtual_address[OFF-1:0];
    assign lvl_rem  = LVL_W'(TL - 1) - lvl_reg;
    assign page_ext = {IDX_W'(0), page};
    assign page_sh  = page_ext >> (OFF * lvl_rem);
    assign lvl_idx  = page_sh[OFF-1:0];
    assign entry_addr = paddr(frame_reg, lvl_idx);
    assign slx      = sl_reg[LVL_W-1:0];
    assign sl_dec   = sl_reg - 1'b1;
    assign slu      = sl_dec[LVL_W-1:0];
    assign iter_addr = paddr(sf_reg[slx], si_reg[slx]);
    assign sl_rem   = SL_W'(TL - 1) - sl_reg;
    assign span     = CNT_W'(1) << (OFF * sl_rem);
    assign target   = CNT_W'(page);
    assign alt      = NP_C - diff_reg;
    assign rd_frame = to_frame(phys_rd_reg);
    assign nf_wide  = {WB'(0), nf_reg};
    assign rd_signed = phys_rd_reg;

    // cyclic distance; a difference beyond the page count has no wrap side
    always_comb
    begin
        if (diff_reg > NP_C)
        begin
            cyc_dist = diff_reg;
        end
        else if (diff_reg > alt)
        begin
            cyc_dist = alt;
        end
        else
        begin
            cyc_dist = diff_reg;
        end
    end

    // physical port address and write data
    always_comb
    begin
        pa  = '0;
        pwd = '0;
        unique case (cmd.phys_sel)
            PA_NONE:   pa = '0;
            PA_ENTRY:  pa = entry_addr;
            PA_ZERO:   pa = paddr(cur_frame_reg, wc_reg);
            PA_ITER:   pa = iter_addr;
            PA_PARENT: pa = (empty_frame_reg != '0) ? empty_parent_reg : best_parent_reg;
            PA_NF:
            begin
                pa  = paddr(nf_reg, wc_reg);
                pwd = (lvl_reg == LVL_W'(TL - 1)) ? swap_rd_reg : '0;
            end
            PA_LINK:
            begin
                pa  = entry_reg;
                pwd = nf_wide[WB-1:0];
            end
            PA_DATA:
            begin
                pa  = paddr(frame_reg, offset);
                pwd = req_reg.write_value[WB-1:0];
            end
            PA_CLEAR:  pa = clr_cnt_reg[PA_W-1:0];
            default:   pa = '0;
        endcase
    end

    // swap port address and write data
    always_comb
    begin
        sa  = '0;
        swd = '0;
        unique case (cmd.swap_sel)
            SA_NONE:  sa = '0;
            SA_OUT:
            begin
                sa  = saddr(best_page_reg, wc_reg);
                swd = phys_rd_reg;
            end
            SA_IN:    sa = saddr(page, wc_reg);
            SA_CLEAR: sa = clr_cnt_reg[SW_AW-1:0];
            default:  sa = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.phys_we)
        begin
            phys_mem[pa] <= pwd;
        end
        phys_rd_reg <= phys_mem[pa];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.swap_we)
        begin
            swap_mem[sa] <= swd;
        end
        swap_rd_reg <= swap_mem[sa];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req;
        end
        if (cmd.walk_init)
        begin
            lvl_reg    <= '0;
            frame_reg  <= '0;
            forbid_reg <= '0;
        end
        if (cmd.walk_adv)
        begin
            lvl_reg    <= lvl_reg + 1'b1;
            frame_reg  <= cmd.adv_from_nf ? nf_reg : rd_frame;
            forbid_reg <= cmd.adv_from_nf ? nf_reg : rd_frame;
        end
        if (cmd.fault_init)
        begin
            entry_reg        <= entry_addr;
            sl_reg           <= '0;
            cur_frame_reg    <= '0;
            cur_parent_reg   <= '0;
            max_frame_reg    <= '0;
            pc_reg           <= '0;
            best_dist_reg    <= '0;
            best_frame_reg   <= '0;
            best_parent_reg  <= '0;
            best_page_reg    <= '0;
            empty_frame_reg  <= '0;
            empty_parent_reg <= '0;
        end
        if (cmd.sc_enter)
        begin
            wc_reg <= '0;
            if (cur_frame_reg > max_frame_reg)
            begin
                max_frame_reg <= cur_frame_reg;
            end
        end
        if (cmd.push)
        begin
            sf_reg[slx] <= cur_frame_reg;
            si_reg[slx] <= '0;
        end
        if (cmd.wc_inc)
        begin
            wc_reg <= wc_reg + 1'b1;
        end
        if (cmd.mark_empty)
        begin
            empty_frame_reg  <= cur_frame_reg;
            empty_parent_reg <= cur_parent_reg;
            pc_reg           <= pc_reg + span;
        end
        if (cmd.descend)
        begin
            cur_frame_reg  <= to_frame(phys_rd_reg);
            cur_parent_reg <= iter_addr;
            sl_reg         <= sl_reg + 1'b1;
        end
        if (cmd.iter_miss)
        begin
            pc_reg      <= pc_reg + span;
            si_reg[slx] <= si_reg[slx] + 1'b1;
        end
        if (cmd.pop)
        begin
            sl_reg      <= sl_dec;
            si_reg[slu] <= si_reg[slu] + 1'b1;
        end
        if (cmd.leaf_a)
        begin
            diff_reg <= (target < pc_reg) ? (pc_reg - target) : (target - pc_reg);
        end
        if (cmd.leaf_b)
        begin
            pc_reg <= pc_reg + 1'b1;
            if (cyc_dist > best_dist_reg)
            begin
                best_dist_reg   <= cyc_dist;
                best_frame_reg  <= cur_frame_reg;
                best_parent_reg <= cur_parent_reg;
                best_page_reg   <= pc_reg[PN_W-1:0];
            end
        end
        if (cmd.decide)
        begin
            wc_reg <= '0;
            priority if (empty_frame_reg != '0)
            begin
                nf_reg <= empty_frame_reg;
            end
            else if (max_frame_reg != FR_MASK)
            begin
                nf_reg <= max_frame_reg + 1'b1;
            end
            else
            begin
                nf_reg <= best_frame_reg;
            end
        end
        if (cmd.set_res)
        begin
            unique case (cmd.res_sel)
                RES_FAIL:
                begin
                    res_value_reg <= '0;
                    res_ok_reg    <= 1'b0;
                end
                RES_WRITE:
                begin
                    res_value_reg <= '0;
                    res_ok_reg    <= 1'b1;
                end
                RES_READ:
                begin
                    res_value_reg <= 32'(rd_signed);
                    res_ok_reg    <= 1'b1;
                end
                default:
                begin
                    res_value_reg <= '0;
                    res_ok_reg    <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_reg.read_value <= res_value_reg;
            out_reg.success    <= res_ok_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        st.clr_done    = &clr_cnt_reg;
        st.va_ok       = (req_reg.virtual_address >> VIRT_ADDR_BITS) == '0;
        st.is_write    = (req_reg.command == CMD_WRITE);
        st.next_nz     = (rd_frame != '0);
        st.walk_last   = (lvl_reg == LVL_W'(TL - 1));
        st.at_leaf     = (sl_reg == SL_W'(TL));
        st.not_forbid  = (cur_frame_reg != forbid_reg);
        st.rd_nz       = (phys_rd_reg != '0);
        st.wc_last     = &wc_reg;
        st.si_cur_last = &si_reg[slx];
        st.si_up_last  = &si_reg[slu];
        st.sl_zero     = (sl_reg == '0);
        st.empty_nz    = (empty_frame_reg != '0);
        st.room        = (max_frame_reg != FR_MASK);
        st.out_free    = !out_valid_reg || rsp_ready;
    end

    a_descend_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.descend |-> (sl_reg < SL_W'(TL)))
        else $error("scan descended below a leaf");

    a_pop_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (sl_reg != '0))
        else $error("scan popped past the root");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("response overwritten before it was taken");

endmodule

// ===== hw/rtl/page_table_walk_with_eviction_top.sv =====
// ============================================================================
// page_table_walk_with_eviction_top - paged word memory with table walk
// Translates word reads and writes through a multi-level page table held in
// physical memory, filling faults and evicting pages to a swap store.
// ============================================================================
// One request transaction carries a read or write of one word at a virtual
// word address; exactly one response transaction comes back with the word
// read (0 on writes) and a success flag, which is 0 only for an address at
// or above 2^VIRT_ADDR_BITS. Requests are handled one at a time: the
// request is taken in the idle state and the response is parked in an
// output register, so a new request is taken while the previous response
// still waits. After reset the block sweeps physical memory and swap one
// word per cycle with a max(PHYS_ADDR_BITS, VIRT_ADDR_BITS)-bit counter (20
// bits with the default sizes) before it takes the first request. Access
// time is set by the single-port physical memory with its registered read;
// a write skips the result state that a read passes through. A missing
// entry starts a depth-first scan of the whole table tree that reads each
// table entry, checks table frames word by word for being empty and
// weighs each resident page as an eviction candidate; it then copies an
// evicted page to swap when no frame is free and fills the new frame.
module page_table_walk_with_eviction_top
    import ptw_pkg::*;
#(
    parameter int OFFSET_BITS    = DEF_OFFSET_BITS,
    parameter int TABLE_LEVELS   = DEF_TABLE_LEVELS,
    parameter int PHYS_ADDR_BITS = DEF_PHYS_ADDR_BITS,
    parameter int VIRT_ADDR_BITS = DEF_VIRT_ADDR_BITS,
    parameter int WORD_BITS      = DEF_WORD_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // command and status bundles between sequencer and datapath
    ptw_cmd_t    cmd;
    ptw_status_t st;

    ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // memories, scan stack and the response register live here
    ptw_datapath #(
        .OFFSET_BITS    (OFFSET_BITS),
        .TABLE_LEVELS   (TABLE_LEVELS),
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS),
        .VIRT_ADDR_BITS (VIRT_ADDR_BITS),
        .WORD_BITS      (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
